@@ sv/fclc_pkg.sv @@
// Shared constants, types and width helpers for the frustum cull / LOD classifier.
`default_nettype none

package fclc_pkg;

   // Default sizing
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int PLANE_COUNT_DEFAULT = 6;

   // Register file layout
   localparam int NUM_PLANES  = 6;
   localparam int PLANE_W     = 64;
   localparam int LIMIT_W     = 48;
   localparam int FIELD_W     = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_BYTE_SH = 3;

   // Fixed-point constants: plane d is Q8.8, coefficients Q2.14
   localparam int D_FRAC_SHIFT   = 14;
   localparam int CULL_THRESHOLD = -16384;
   localparam int CLAMP_LOG      = 20;
   localparam int LIMIT_SQ_W     = 2 * FIELD_W + 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PLANE_LEFT,
      REG_PLANE_RIGHT,
      REG_PLANE_BOTTOM,
      REG_PLANE_TOP,
      REG_PLANE_NEAR,
      REG_PLANE_FAR,
      REG_LOD_LIMITS
   } reg_index_type;

   typedef enum logic [1:0] {
      LEVEL_FULL,
      LEVEL_HALF,
      LEVEL_QUARTER,
      LEVEL_CULLED
   } level_type;

   typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] plane_array_type;

   // Width of a clamped |min + max| value
   function automatic int clamp_width(input int cw);
      return (cw + 1 > CLAMP_LOG + 1) ? CLAMP_LOG + 1 : cw + 1;
   endfunction

   // Width of the sum of three squared clamped values
   function automatic int dist_sq_width(input int cw);
      return 2 * clamp_width(cw) + 2;
   endfunction

endpackage

`default_nettype wire

@@ sv/fclc_csr.sv @@
// Configuration register file: six planes and the LOD limits behind an APB-style port.
`default_nettype none

module fclc_csr
   import fclc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   psel,
   input  wire logic                   penable,
   input  wire logic                   pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  paddr,
   input  wire logic [CSR_DATA_W-1:0]  pwdata,
   output logic      [CSR_DATA_W-1:0]  prdata,
   output logic                        pready,
   output plane_array_type             planes,
   output logic      [LIMIT_W-1:0]     lod_limits
);

   plane_array_type      planes_ff;
   logic [LIMIT_W-1:0]   lod_limits_ff;
   reg_index_type        reg_index;
   logic                 write_en;

   // Decode the register slot from the byte address
   assign reg_index = reg_index_type'(paddr[CSR_BYTE_SH +: CSR_INDEX_W]);
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Write registers; slots past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         planes_ff     <= '0;
         lod_limits_ff <= '0;
      end else if (write_en) begin
         unique case (reg_index)
            REG_PLANE_LEFT:   planes_ff[REG_PLANE_LEFT]   <= pwdata;
            REG_PLANE_RIGHT:  planes_ff[REG_PLANE_RIGHT]  <= pwdata;
            REG_PLANE_BOTTOM: planes_ff[REG_PLANE_BOTTOM] <= pwdata;
            REG_PLANE_TOP:    planes_ff[REG_PLANE_TOP]    <= pwdata;
            REG_PLANE_NEAR:   planes_ff[REG_PLANE_NEAR]   <= pwdata;
            REG_PLANE_FAR:    planes_ff[REG_PLANE_FAR]    <= pwdata;
            REG_LOD_LIMITS:   lod_limits_ff <= pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_index)
         REG_PLANE_LEFT:   prdata = planes_ff[REG_PLANE_LEFT];
         REG_PLANE_RIGHT:  prdata = planes_ff[REG_PLANE_RIGHT];
         REG_PLANE_BOTTOM: prdata = planes_ff[REG_PLANE_BOTTOM];
         REG_PLANE_TOP:    prdata = planes_ff[REG_PLANE_TOP];
         REG_PLANE_NEAR:   prdata = planes_ff[REG_PLANE_NEAR];
         REG_PLANE_FAR:    prdata = planes_ff[REG_PLANE_FAR];
         REG_LOD_LIMITS:   prdata = CSR_DATA_W'(lod_limits_ff);
         default:          prdata = '0;
      endcase
   end

   assign planes     = planes_ff;
   assign lod_limits = lod_limits_ff;

endmodule

`default_nettype wire

@@ sv/fclc_plane.sv @@
// One plane test: positive-vertex products, then distance sum and cull compare.
`default_nettype none

module fclc_plane
   import fclc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
   input  wire logic                        clock,
   input  wire logic                        advance,
   input  wire logic [PLANE_W-1:0]          plane,
   input  wire logic [2:0][COORD_WIDTH-1:0] min_pt,
   input  wire logic [2:0][COORD_WIDTH-1:0] max_pt,
   output logic                             cull
);

   localparam int PROD_W  = FIELD_W + COORD_WIDTH;
   localparam int DTERM_W = FIELD_W + D_FRAC_SHIFT;
   localparam int ACC_W   = ((PROD_W > DTERM_W) ? PROD_W : DTERM_W) + 2;
   localparam logic signed [ACC_W-1:0] THRESH = ACC_W'(CULL_THRESHOLD);

   logic signed [2:0][PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0]      prod_ff [3];
   logic signed [DTERM_W-1:0]     dterm_in;
   logic signed [DTERM_W-1:0]     dterm_ff;
   logic signed [ACC_W-1:0]       acc;
   logic                          cull_in;
   logic                          cull_ff;

   // Pick the positive vertex per axis and multiply by the coefficient
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [FIELD_W-1:0]     coef;
         logic signed [COORD_WIDTH-1:0] vert;
         coef = $signed(plane[FIELD_W*k +: FIELD_W]);
         vert = coef[FIELD_W-1] ? $signed(min_pt[k]) : $signed(max_pt[k]);
         prod_in[k] = PROD_W'(coef) * PROD_W'(vert);
      end
      dterm_in = $signed({plane[FIELD_W*3 +: FIELD_W], {D_FRAC_SHIFT{1'b0}}});
   end

   // Sum the distance and compare against minus one Q8.8 LSB
   always_comb begin
      acc = ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2])
          + ACC_W'(dterm_ff);
      cull_in = acc < THRESH;
   end

   // Advance both stages together; hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         dterm_ff <= dterm_in;
         cull_ff  <= cull_in;
      end
   end

   assign cull = cull_ff;

endmodule

`default_nettype wire

@@ sv/fclc_lod.sv @@
// Box center distance squared and squared LOD limits, both scaled by four, two register stages.
`default_nettype none

module fclc_lod
   import fclc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)
(
   input  wire logic                                     clock,
   input  wire logic                                     advance,
   input  wire logic [2:0][COORD_WIDTH-1:0]              min_pt,
   input  wire logic [2:0][COORD_WIDTH-1:0]              max_pt,
   input  wire logic [LIMIT_W-1:0]                       lod_limits,
   output logic      [dist_sq_width(COORD_WIDTH)-1:0]    dist_sq,
   output logic      [2:0][LIMIT_SQ_W-1:0]               limit_sq
);

   localparam int SUM_W   = COORD_WIDTH + 1;
   localparam int CLAMP_W = clamp_width(COORD_WIDTH);
   localparam int SQ1_W   = 2 * CLAMP_W;
   localparam int SQ_W    = dist_sq_width(COORD_WIDTH);
   localparam int LSQ_W   = 2 * FIELD_W;

   logic [2:0][CLAMP_W-1:0] mag_c;
   logic [2:0][SQ1_W-1:0]   sq_in;
   logic [SQ1_W-1:0]        sq_ff [3];
   logic [2:0][LSQ_W-1:0]   lim_sq_in;
   logic [LSQ_W-1:0]        lim_sq_ff [3];
   logic [SQ_W-1:0]         dist_sq_in;
   logic [SQ_W-1:0]         dist_sq_ff;
   logic [LIMIT_SQ_W-1:0]   limit4_ff [3];

   // Per axis: s = min + max, magnitude, clamp
   for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [SUM_W-1:0] s;
      logic        [SUM_W-1:0] mag;
      assign s   = SUM_W'($signed(min_pt[k])) + SUM_W'($signed(max_pt[k]));
      assign mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      if (SUM_W > CLAMP_W) begin : g_clamp
         localparam logic [SUM_W-1:0] LIMIT_WIDE = SUM_W'(1) << CLAMP_LOG;
         assign mag_c[k] = (mag > LIMIT_WIDE) ? CLAMP_W'(LIMIT_WIDE)
                                              : mag[CLAMP_W-1:0];
      end else begin : g_pass
         assign mag_c[k] = mag[CLAMP_W-1:0];
      end
   end

   // Square magnitudes and limits
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k]     = SQ1_W'(mag_c[k]) * SQ1_W'(mag_c[k]);
         lim_sq_in[k] = LSQ_W'(lod_limits[FIELD_W*k +: FIELD_W])
                      * LSQ_W'(lod_limits[FIELD_W*k +: FIELD_W]);
      end
   end

   // Sum the three squares
   assign dist_sq_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]     <= sq_in[k];
            lim_sq_ff[k] <= lim_sq_in[k];
            limit4_ff[k] <= {lim_sq_ff[k], 2'b00};
         end
         dist_sq_ff <= dist_sq_in;
      end
   end

   assign dist_sq = dist_sq_ff;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         limit_sq[k] = limit4_ff[k];
      end
   end

endmodule

`default_nettype wire

@@ sv/frustum_cull_lod_classifier.sv @@
// Each accepted box beat passes every stage below before its detail_level beat appears on rsp.
// Throughput: one box per cycle unless stalled; one global pipeline enable advances all stages.
// A stall on rsp with a full output register freezes every stage and raises req_stall.
// Stages: capture, plane products and squares, distance sums, level select.
// Reset clears all valid bits and the plane and limit registers to zero.
`default_nettype none

module frustum_cull_lod_classifier
   import fclc_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT,
   parameter int PLANE_COUNT = PLANE_COUNT_DEFAULT
)
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   // box input channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_WIDTH-1:0] req_min_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_min_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_min_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_max_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_max_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_max_z,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [1:0]                    rsp_detail_level,
   // configuration port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         paddr,
   input  wire logic [CSR_DATA_W-1:0]         pwdata,
   output logic      [CSR_DATA_W-1:0]         prdata,
   output logic                               pready
);

   localparam int SQ_W  = dist_sq_width(COORD_WIDTH);
   localparam int CMP_W = (SQ_W > LIMIT_SQ_W) ? SQ_W : LIMIT_SQ_W;

   plane_array_type               planes;
   logic [LIMIT_W-1:0]            lod_limits;
   logic                          advance;
   logic                          s1_valid_ff;
   logic                          s2_valid_ff;
   logic                          s3_valid_ff;
   logic                          rsp_valid_ff;
   logic [2:0][COORD_WIDTH-1:0]   min_pt_ff;
   logic [2:0][COORD_WIDTH-1:0]   max_pt_ff;
   logic [PLANE_COUNT-1:0]        plane_cull;
   logic [SQ_W-1:0]               dist_sq;
   logic [2:0][LIMIT_SQ_W-1:0]    limit_sq;
   logic [2:0]                    in_limit;
   level_type                     level_in;
   level_type                     level_ff;

   fclc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .planes     (planes),
      .lod_limits (lod_limits)
   );

   // Whole pipeline moves unless the output beat is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Capture the box corners
   always_ff @(posedge clock) begin
      if (advance) begin
         min_pt_ff <= {req_min_z, req_min_y, req_min_x};
         max_pt_ff <= {req_max_z, req_max_y, req_max_x};
      end
   end

   // Plane tests, one unit per enabled plane
   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
      fclc_plane #(
         .COORD_WIDTH (COORD_WIDTH)
      ) u_plane (
         .clock   (clock),
         .advance (advance),
         .plane   (planes[i]),
         .min_pt  (min_pt_ff),
         .max_pt  (max_pt_ff),
         .cull    (plane_cull[i])
      );
   end

   fclc_lod #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_lod (
      .clock      (clock),
      .advance    (advance),
      .min_pt     (min_pt_ff),
      .max_pt     (max_pt_ff),
      .lod_limits (lod_limits),
      .dist_sq    (dist_sq),
      .limit_sq   (limit_sq)
   );

   // Compare against each limit; any plane cull wins, else pick the first limit hit in order, else cull
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         in_limit[k] = CMP_W'(dist_sq) < CMP_W'(limit_sq[k]);
      end
      priority if (|plane_cull) begin
         level_in = LEVEL_CULLED;
      end else if (in_limit[0]) begin
         level_in = LEVEL_FULL;
      end else if (in_limit[1]) begin
         level_in = LEVEL_HALF;
      end else if (in_limit[2]) begin
         level_in = LEVEL_QUARTER;
      end else begin
         level_in = LEVEL_CULLED;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_detail_level = level_ff;

endmodule

`default_nettype wire
